[rtl/nhe_pkg.sv]
// ----------------------------------------------------------------------------
// nhe_pkg
// Shared types, status codes and the normalization factor function of the
// normalized Hermite evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package nhe_pkg;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NOINIT = 2'd1,
        STATUS_RANGE  = 2'd2,
        STATUS_SAT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MEAN_OFFSET = 2'd0,
        REG_INV_SCALE   = 2'd1,
        REG_NUM_FACTORS = 2'd2
    } cfg_reg_t;

    localparam logic [63:0] POS_LIM64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] H0_ONE    = 64'h0000_0001_0000_0000;

    // Data handed from cell to cell. h1/h2 are H(i-1)/H(i-2), signed Q32.32.
    typedef struct packed {
        status_t     code;
        logic        sat;
        logic [5:0]  degree;
        logic [32:0] ymag2;  // |2y|, Q16.16
        logic        yneg;
        logic [63:0] h1;
        logic [63:0] h2;
    } chain_t;

    // round(2^31 / sqrt(2^n n!)) in Q1.31, zero once 2^n n! leaves 64 bits.
    // Elaboration only.
    function automatic logic [31:0] norm_factor(input int unsigned n);
        logic [63:0]  p;
        logic [127:0] wide;
        logic         big;
        logic [32:0]  lo;
        logic [32:0]  hi;
        logic [32:0]  mid;
        logic [63:0]  c;
        int unsigned  j;
        p   = 64'd1;
        big = 1'b0;
        for (j = 1; j <= n; j++) begin
            if (!big) begin
                wide = 128'(p) * 128'(2 * j);
                if (wide[127:64] != 64'd0) begin
                    big = 1'b1;
                end else begin
                    p = wide[63:0];
                end
            end
        end
        lo = 33'd0;
        hi = 33'h0_8000_0000;
        for (j = 0; j < 40; j++) begin
            if (lo < hi) begin
                mid  = (lo + hi + 33'd1) >> 1;
                c    = {30'd0, mid, 1'b0} - 64'd1;
                wide = 128'(c * c) * 128'(p);
                if (wide <= (128'd1 << 64)) begin
                    lo = mid;
                end else begin
                    hi = mid - 33'd1;
                end
            end
        end
        return big ? 32'd0 : lo[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/nhe_scale.sv]
// ----------------------------------------------------------------------------
// nhe_scale
// Front end: status decision and y = (x - mean) * inv_scale in Q16.16 with
// saturation, then the recurrence seed H0, H1 for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module nhe_scale #(
    parameter int MAX_DEGREE = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [31:0]       sample,
    input  logic [5:0]        degree,
    input  logic [31:0]       mean_offset,
    input  logic [31:0]       inv_scale,
    input  logic [4:0]        num_factors,
    output logic              out_valid,
    output nhe_pkg::chain_t   out_data
);

    logic [4:0]       vld_reg;

    logic [31:0]      s1_x_reg;
    logic [5:0]       s1_deg_reg;
    nhe_pkg::status_t s1_code_reg;
    nhe_pkg::status_t s1_code_next;

    logic [32:0]      s2_dmag_reg;
    logic [32:0]      s2_dmag_next;
    logic             s2_neg_reg;
    logic [32:0]      s2_diff;
    logic [5:0]       s2_deg_reg;
    nhe_pkg::status_t s2_code_reg;

    logic [64:0]      s3_prod_reg;
    logic             s3_neg_reg;
    logic [5:0]       s3_deg_reg;
    nhe_pkg::status_t s3_code_reg;

    logic [31:0]      s4_ymag_reg;
    logic [31:0]      s4_ymag_next;
    logic             s4_neg_reg;
    logic             s4_sat_reg;
    logic             s4_sat_next;
    logic [31:0]      s4_lim;
    logic [5:0]       s4_deg_reg;
    nhe_pkg::status_t s4_code_reg;

    nhe_pkg::chain_t  out_reg;
    nhe_pkg::chain_t  out_next;
    logic [31:0]      y_val;

    always_comb begin
        if (num_factors == 5'd0) begin
            s1_code_next = nhe_pkg::STATUS_NOINIT;
        end else if ((degree >= {1'b0, num_factors}) ||
                     (32'(degree) >= 32'(MAX_DEGREE))) begin
            s1_code_next = nhe_pkg::STATUS_RANGE;
        end else begin
            s1_code_next = nhe_pkg::STATUS_OK;
        end
    end

    assign s2_diff      = {s1_x_reg[31], s1_x_reg} - {mean_offset[31], mean_offset};
    assign s2_dmag_next = s2_diff[32] ? (~s2_diff + 33'd1) : s2_diff;

    assign s4_lim       = s3_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign s4_sat_next  = s3_prod_reg[64:24] > {9'd0, s4_lim};
    assign s4_ymag_next = s4_sat_next ? s4_lim : s3_prod_reg[55:24];

    assign y_val = s4_neg_reg ? (~s4_ymag_reg + 32'd1) : s4_ymag_reg;

    always_comb begin
        out_next.code   = s4_code_reg;
        out_next.sat    = s4_sat_reg;
        out_next.degree = s4_deg_reg;
        out_next.ymag2  = {s4_ymag_reg, 1'b0};
        out_next.yneg   = s4_neg_reg;
        out_next.h1     = {{15{y_val[31]}}, y_val, 17'd0};
        out_next.h2     = nhe_pkg::H0_ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_x_reg    <= sample;
            s1_deg_reg  <= degree;
            s1_code_reg <= s1_code_next;

            s2_dmag_reg <= s2_dmag_next;
            s2_neg_reg  <= s2_diff[32];
            s2_deg_reg  <= s1_deg_reg;
            s2_code_reg <= s1_code_reg;

            s3_prod_reg <= {32'd0, s2_dmag_reg} * {33'd0, inv_scale};
            s3_neg_reg  <= s2_neg_reg;
            s3_deg_reg  <= s2_deg_reg;
            s3_code_reg <= s2_code_reg;

            s4_ymag_reg <= s4_ymag_next;
            s4_sat_reg  <= s4_sat_next;
            s4_neg_reg  <= s3_neg_reg;
            s4_deg_reg  <= s3_deg_reg;
            s4_code_reg <= s3_code_reg;

            out_reg     <= out_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[rtl/nhe_cell.sv]
// ----------------------------------------------------------------------------
// nhe_cell
// One recurrence step H(i) = 2y*H(i-1) - 2(i-1)*H(i-2), saturating, in five
// stages. Passes the transaction through unchanged when degree < i.
// ----------------------------------------------------------------------------
`default_nettype none

module nhe_cell #(
    parameter int STEP_INDEX = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  nhe_pkg::chain_t in_data,
    output logic            out_valid,
    output nhe_pkg::chain_t out_data
);

    localparam int            KW = $clog2(2 * STEP_INDEX);
    localparam int            QW = 64 + KW;
    localparam logic [KW-1:0] QK = KW'(2 * (STEP_INDEX - 1));

    logic [4:0]      vld_reg;

    nhe_pkg::chain_t a_chain_reg;
    logic [63:0]     a_mag1_reg;
    logic [63:0]     a_mag1_next;
    logic [63:0]     a_mag2_reg;
    logic [63:0]     a_mag2_next;
    logic            a_neg1_reg;
    logic            a_neg2_reg;
    logic            a_act_reg;

    nhe_pkg::chain_t b_chain_reg;
    logic [64:0]     b_pphi_reg;
    logic [64:0]     b_pplo_reg;
    logic [QW-1:0]   b_qm_reg;
    logic            b_neg1_reg;
    logic            b_neg2_reg;
    logic            b_act_reg;

    nhe_pkg::chain_t c_chain_reg;
    logic [96:0]     c_sum;
    logic [80:0]     c_m1_reg;
    logic [QW-1:0]   c_qm_reg;
    logic            c_neg1_reg;
    logic            c_neg2_reg;
    logic            c_act_reg;

    nhe_pkg::chain_t d_chain_reg;
    logic [63:0]     d_lim1;
    logic [63:0]     d_lim2;
    logic            d_over1;
    logic            d_over2;
    logic [63:0]     d_mm1;
    logic [63:0]     d_mm2;
    logic [63:0]     d_p_reg;
    logic [63:0]     d_p_next;
    logic [63:0]     d_q_reg;
    logic [63:0]     d_q_next;
    logic            d_sat_reg;
    logic            d_act_reg;

    logic [64:0]     e_diff;
    logic            e_ovf;
    logic [63:0]     e_res;
    nhe_pkg::chain_t out_reg;
    nhe_pkg::chain_t out_next;

    assign a_mag1_next = in_data.h1[63] ? (~in_data.h1 + 64'd1) : in_data.h1;
    assign a_mag2_next = in_data.h2[63] ? (~in_data.h2 + 64'd1) : in_data.h2;

    assign c_sum = {b_pphi_reg, 32'd0} + {32'd0, b_pplo_reg};

    assign d_lim1   = c_neg1_reg ? nhe_pkg::NEG_LIM64 : nhe_pkg::POS_LIM64;
    assign d_lim2   = c_neg2_reg ? nhe_pkg::NEG_LIM64 : nhe_pkg::POS_LIM64;
    assign d_over1  = c_m1_reg > {17'd0, d_lim1};
    assign d_over2  = c_qm_reg > {{KW{1'b0}}, d_lim2};
    assign d_mm1    = d_over1 ? d_lim1 : c_m1_reg[63:0];
    assign d_mm2    = d_over2 ? d_lim2 : c_qm_reg[63:0];
    assign d_p_next = c_neg1_reg ? (~d_mm1 + 64'd1) : d_mm1;
    assign d_q_next = c_neg2_reg ? (~d_mm2 + 64'd1) : d_mm2;

    assign e_diff = {d_p_reg[63], d_p_reg} - {d_q_reg[63], d_q_reg};
    assign e_ovf  = e_diff[64] != e_diff[63];
    assign e_res  = e_ovf ? (e_diff[64] ? nhe_pkg::NEG_LIM64 : nhe_pkg::POS_LIM64)
                          : e_diff[63:0];

    always_comb begin
        out_next = d_chain_reg;
        if (d_act_reg) begin
            out_next.h1  = e_res;
            out_next.h2  = d_chain_reg.h1;
            out_next.sat = d_chain_reg.sat | d_sat_reg | e_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_chain_reg <= in_data;
            a_mag1_reg  <= a_mag1_next;
            a_mag2_reg  <= a_mag2_next;
            a_neg1_reg  <= in_data.h1[63] ^ in_data.yneg;
            a_neg2_reg  <= in_data.h2[63];
            a_act_reg   <= in_data.degree >= 6'(STEP_INDEX);

            b_chain_reg <= a_chain_reg;
            b_pphi_reg  <= {33'd0, a_mag1_reg[63:32]} * {32'd0, a_chain_reg.ymag2};
            b_pplo_reg  <= {33'd0, a_mag1_reg[31:0]} * {32'd0, a_chain_reg.ymag2};
            b_qm_reg    <= {{KW{1'b0}}, a_mag2_reg} * {64'd0, QK};
            b_neg1_reg  <= a_neg1_reg;
            b_neg2_reg  <= a_neg2_reg;
            b_act_reg   <= a_act_reg;

            c_chain_reg <= b_chain_reg;
            c_m1_reg    <= c_sum[96:16];
            c_qm_reg    <= b_qm_reg;
            c_neg1_reg  <= b_neg1_reg;
            c_neg2_reg  <= b_neg2_reg;
            c_act_reg   <= b_act_reg;

            d_chain_reg <= c_chain_reg;
            d_p_reg     <= d_p_next;
            d_q_reg     <= d_q_next;
            d_sat_reg   <= d_over1 | d_over2;
            d_act_reg   <= c_act_reg;

            out_reg     <= out_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[rtl/nhe_norm.sv]
// ----------------------------------------------------------------------------
// nhe_norm
// Back end: picks H(n), multiplies by the 1/sqrt(2^n n!) factor table in
// Q1.31 and forms the final value and status. Last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nhe_norm #(
    parameter int MAX_DEGREE = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_valid,
    input  nhe_pkg::chain_t  in_data,
    output logic             out_valid,
    output logic [63:0]      value,
    output nhe_pkg::status_t status
);

    localparam int IDX_W     = $clog2(MAX_DEGREE);
    localparam int ROM_DEPTH = 2 ** IDX_W;

    logic [31:0]      rom_w [ROM_DEPTH];

    logic [3:0]       vld_reg;

    logic [63:0]      n1_h;
    logic [63:0]      n1_mag_reg;
    logic [63:0]      n1_mag_next;
    logic [31:0]      n1_fac_reg;
    logic             n1_neg_reg;
    logic             n1_sat_reg;
    nhe_pkg::status_t n1_code_reg;

    logic [63:0]      n2_pphi_reg;
    logic [63:0]      n2_pplo_reg;
    logic             n2_neg_reg;
    logic             n2_sat_reg;
    nhe_pkg::status_t n2_code_reg;

    logic [96:0]      n3_sum;
    logic [65:0]      n3_m;
    logic [63:0]      n3_lim;
    logic             n3_over;
    logic [63:0]      n3_mm_reg;
    logic             n3_neg_reg;
    logic             n3_sat_reg;
    nhe_pkg::status_t n3_code_reg;

    logic [63:0]      value_reg;
    logic [63:0]      value_next;
    nhe_pkg::status_t status_reg;
    nhe_pkg::status_t status_next;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam logic [31:0] ENTRY = (g < MAX_DEGREE) ? nhe_pkg::norm_factor(g) : 32'd0;
        assign rom_w[g] = ENTRY;
    end

    assign n1_h        = (in_data.degree == 6'd0) ? nhe_pkg::H0_ONE : in_data.h1;
    assign n1_mag_next = n1_h[63] ? (~n1_h + 64'd1) : n1_h;

    assign n3_sum  = {1'b0, n2_pphi_reg, 32'd0} + {33'd0, n2_pplo_reg};
    assign n3_m    = n3_sum[96:31];
    assign n3_lim  = n2_neg_reg ? nhe_pkg::NEG_LIM64 : nhe_pkg::POS_LIM64;
    assign n3_over = n3_m > {2'd0, n3_lim};

    always_comb begin
        if (n3_code_reg != nhe_pkg::STATUS_OK) begin
            value_next  = 64'd0;
            status_next = n3_code_reg;
        end else begin
            value_next  = n3_neg_reg ? (~n3_mm_reg + 64'd1) : n3_mm_reg;
            status_next = n3_sat_reg ? nhe_pkg::STATUS_SAT : nhe_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            n1_mag_reg  <= n1_mag_next;
            n1_fac_reg  <= rom_w[in_data.degree[IDX_W-1:0]];
            n1_neg_reg  <= n1_h[63];
            n1_sat_reg  <= in_data.sat;
            n1_code_reg <= in_data.code;

            n2_pphi_reg <= {32'd0, n1_mag_reg[63:32]} * {32'd0, n1_fac_reg};
            n2_pplo_reg <= {32'd0, n1_mag_reg[31:0]} * {32'd0, n1_fac_reg};
            n2_neg_reg  <= n1_neg_reg;
            n2_sat_reg  <= n1_sat_reg;
            n2_code_reg <= n1_code_reg;

            n3_mm_reg   <= n3_over ? n3_lim : n3_m[63:0];
            n3_neg_reg  <= n2_neg_reg;
            n3_sat_reg  <= n2_sat_reg | n3_over;
            n3_code_reg <= n2_code_reg;

            value_reg   <= value_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

[rtl/normalized_hermite_evaluator.sv]
// ----------------------------------------------------------------------------
// normalized_hermite_evaluator
// Evaluates the normalized physicists' Hermite polynomial H(n, y)/sqrt(2^n n!)
// at y = (x - mean_offset) * inv_scale, with saturation and status.
// ----------------------------------------------------------------------------
// A new transaction can be accepted every clock cycle unless a result is
// stalled on m_tready. Each result passes through five front-end stages for
// scaling, one five-stage cell per recurrence step from degree 2 to
// MAX_DEGREE-1, and four stages for the normalization multiply and output
// register. The whole pipeline holds while a result waits on m_tready.
// The user must write configuration through cfg_wr_en/cfg_index/cfg_wr_data
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module normalized_hermite_evaluator #(
    parameter int MAX_DEGREE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] sample, [37:32] degree

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int NCELL = MAX_DEGREE - 2;

    logic [31:0]      mean_offset_reg;
    logic [31:0]      inv_scale_reg;
    logic [4:0]       num_factors_reg;

    logic             advance;
    logic             chain_vld [NCELL+1];
    nhe_pkg::chain_t  chain_dat [NCELL+1];
    nhe_pkg::status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_offset_reg <= 32'd0;
            inv_scale_reg   <= 32'h0100_0000;
            num_factors_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                nhe_pkg::REG_MEAN_OFFSET: mean_offset_reg <= cfg_wr_data;
                nhe_pkg::REG_INV_SCALE:   inv_scale_reg   <= cfg_wr_data;
                nhe_pkg::REG_NUM_FACTORS: num_factors_reg <= cfg_wr_data[4:0];
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    nhe_scale #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .sample      (s_tdata[31:0]),
        .degree      (s_tdata[37:32]),
        .mean_offset (mean_offset_reg),
        .inv_scale   (inv_scale_reg),
        .num_factors (num_factors_reg),
        .out_valid   (chain_vld[0]),
        .out_data    (chain_dat[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        nhe_cell #(
            .STEP_INDEX (k + 2)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_vld[k]),
            .in_data   (chain_dat[k]),
            .out_valid (chain_vld[k+1]),
            .out_data  (chain_dat[k+1])
        );
    end

    nhe_norm #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (chain_vld[NCELL]),
        .in_data   (chain_dat[NCELL]),
        .out_valid (m_tvalid),
        .value     (m_tdata),
        .status    (status)
    );

    assign m_tuser = status;

`ifndef SYNTHESIS
    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    a_zero_on_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == nhe_pkg::STATUS_NOINIT ||
                     m_tuser == nhe_pkg::STATUS_RANGE) |-> m_tdata == 64'd0)
        else $error("nonzero value on rejected transaction");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for normalized_hermite_evaluator. Drives samples and degrees on
// the input stream, computes each expected value and status with its own
// fixed-point model of the scaling, the Hermite recurrence and the
// normalization table, and checks every result transaction in order. Covers
// the uninitialized and out-of-range cases, scaling and recurrence saturation,
// the ignored register index, and random traffic under three idle profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int          MAX_DEGREE   = 16;
    localparam int          PIPE_LATENCY = 9 + 5 * (MAX_DEGREE - 2);
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SEG_ITEMS    = 33;
    localparam int          MAX_PRINTS   = 40;

    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    localparam logic [31:0] SCALE_ONE    = 32'h0100_0000;

    typedef struct packed {
        logic [63:0]      value;
        nhe_pkg::status_t status;
    } hermite_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] sample, [37:32] degree
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] value
    logic [1:0]  m_tuser;   // [1:0] status

    // model copy of the block's registers and normalization table
    logic [31:0]     cfg_mean;
    logic [31:0]     cfg_scale;
    logic [4:0]      cfg_nfact;
    logic [31:0]     norm_table [MAX_DEGREE];

    hermite_result_t pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int samples_sent;
    int results_checked;
    int reg_writes;
    int mismatches;
    int cycle_count;

    normalized_hermite_evaluator #(
        .MAX_DEGREE(MAX_DEGREE)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------

    // (a*b) >> s, truncated toward zero, saturated to 64 bits
    function automatic logic signed [63:0] mul_shift_sat(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int s,
                                                         inout logic sat);
        logic         neg;
        logic [63:0]  au;
        logic [63:0]  bu;
        logic [127:0] prod;
        logic [127:0] lim;
        logic [63:0]  m;
        neg  = a[63] ^ b[63];
        au   = a[63] ? (~a + 64'd1) : a;
        bu   = b[63] ? (~b + 64'd1) : b;
        prod = ({64'd0, au} * {64'd0, bu}) >> s;
        lim  = neg ? {64'd0, nhe_pkg::NEG_LIM64} : {64'd0, nhe_pkg::POS_LIM64};
        if (prod > lim) begin
            sat = 1'b1;
            m   = lim[63:0];
        end else begin
            m = prod[63:0];
        end
        return neg ? (~m + 64'd1) : m;
    endfunction

    function automatic logic signed [63:0] sub_sat64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     inout logic sat);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) begin
            sat = 1'b1;
            return d[64] ? nhe_pkg::NEG_LIM64 : nhe_pkg::POS_LIM64;
        end
        return d[63:0];
    endfunction

    // largest v <= 2^31 with (2v-1)^2 * p <= 2^64, i.e. round(2^31/sqrt(p))
    function automatic logic [31:0] recip_sqrt_q31(input logic [63:0] p);
        logic [32:0]  lo;
        logic [32:0]  hi;
        logic [32:0]  mid;
        logic [127:0] c;
        lo = 33'd0;
        hi = 33'h0_8000_0000;
        while (lo < hi) begin
            mid = (lo + hi + 33'd1) >> 1;
            c   = {94'd0, mid, 1'b0} - 128'd1;
            if (c * c * {64'd0, p} <= (128'd1 << 64)) begin
                lo = mid;
            end else begin
                hi = mid - 33'd1;
            end
        end
        return lo[31:0];
    endfunction

    task automatic build_norm_table();
        logic [63:0]  p;
        logic [127:0] wide;
        logic         big;
        p   = 64'd1;
        big = 1'b0;
        for (int n = 0; n < MAX_DEGREE; n++) begin
            if (n > 0 && !big) begin
                wide = {64'd0, p} * 128'(2 * n);
                if (wide[127:64] != 64'd0) begin
                    big = 1'b1;
                end else begin
                    p = wide[63:0];
                end
            end
            norm_table[n] = big ? 32'd0 : recip_sqrt_q31(p);
        end
    endtask

    function automatic hermite_result_t predict_hermite(input logic [31:0] x,
                                                        input logic [5:0] n);
        hermite_result_t  r;
        int               limit;
        logic             sat;
        logic signed [63:0] diff;
        logic signed [63:0] y;
        logic signed [63:0] h;
        logic signed [63:0] h1;
        logic signed [63:0] h2;
        logic signed [63:0] p;
        logic signed [63:0] q;
        limit = (cfg_nfact < MAX_DEGREE) ? int'(cfg_nfact) : MAX_DEGREE;
        sat   = 1'b0;
        r.value = 64'd0;
        if (cfg_nfact == 5'd0) begin
            r.status = nhe_pkg::STATUS_NOINIT;
            return r;
        end
        if (int'(n) >= limit) begin
            r.status = nhe_pkg::STATUS_RANGE;
            return r;
        end
        diff = {{32{x[31]}}, x} - {{32{cfg_mean[31]}}, cfg_mean};
        y    = mul_shift_sat(diff, {32'd0, cfg_scale}, 24, sat);
        if (y > 64'sh0000_0000_7FFF_FFFF) begin
            y   = 64'sh0000_0000_7FFF_FFFF;
            sat = 1'b1;
        end else if (y < -64'sh0000_0000_8000_0000) begin
            y   = -64'sh0000_0000_8000_0000;
            sat = 1'b1;
        end
        h2 = nhe_pkg::H0_ONE;
        h1 = y <<< 17;
        if (n == 6'd0) begin
            h = h2;
        end else begin
            h = h1;
            for (int i = 2; i <= int'(n); i++) begin
                p  = mul_shift_sat(h1, y <<< 1, 16, sat);
                q  = mul_shift_sat(h2, 64'(2 * (i - 1)), 0, sat);
                h  = sub_sat64(p, q, sat);
                h2 = h1;
                h1 = h;
            end
        end
        h        = mul_shift_sat(h, {32'd0, norm_table[n]}, 31, sat);
        r.value  = h;
        r.status = sat ? nhe_pkg::STATUS_SAT : nhe_pkg::STATUS_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        hermite_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                          m_tdata, m_tuser));
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.value) begin
                    report_mismatch($sformatf("result %0d value %h, want %h",
                                              results_checked, m_tdata, exp_r.value));
                end
                if (m_tuser !== exp_r.status) begin
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_checked, m_tuser, exp_r.status));
                end
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // Entered at a falling edge; returns at the falling edge after the
    // transaction, with tvalid still high so a following call can reuse it.
    task automatic send_sample(input logic [31:0] x, input logic [5:0] n);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, n, x};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_hermite(x, n));
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        case (idx)
            nhe_pkg::REG_MEAN_OFFSET: cfg_mean  = data;
            nhe_pkg::REG_INV_SCALE:   cfg_scale = data;
            nhe_pkg::REG_NUM_FACTORS: cfg_nfact = data[4:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_regs(input logic [31:0] mean_d, input logic [31:0] scale_d,
                                input logic [31:0] nfact_d, input bit poke_unused);
        wait_drained();
        write_reg(nhe_pkg::REG_MEAN_OFFSET, mean_d);
        write_reg(nhe_pkg::REG_INV_SCALE, scale_d);
        write_reg(nhe_pkg::REG_NUM_FACTORS, nfact_d);
        if (poke_unused) begin
            write_reg(REG_UNUSED, $urandom());
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_not_initialized();
        send_sample(32'h0000_0000, 6'd0);
        send_sample(32'h7FFF_FFFF, 6'd63);
        send_sample(32'h8000_0000, 6'd5);
    endtask

    task automatic test_degree_range();
        program_regs(32'h0000_0000, SCALE_ONE, 32'd5, 1'b0);
        send_sample(32'h0000_8000, 6'd4);
        send_sample(32'h0000_8000, 6'd5);
        send_sample(32'h0000_8000, 6'd63);
        // values above the table depth clamp to it; upper data bits are dropped
        program_regs(32'h0000_0000, SCALE_ONE, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0001_0000, 6'd15);
        send_sample(32'h0001_0000, 6'd16);
        program_regs(32'h0000_0000, SCALE_ONE, 32'd1, 1'b0);
        send_sample(32'hFFFF_0000, 6'd0);
        send_sample(32'hFFFF_0000, 6'd1);
    endtask

    task automatic test_extreme_samples();
        program_regs(32'h0000_0000, SCALE_ONE, 32'd16, 1'b0);
        send_sample(32'h0000_0000, 6'd0);
        send_sample(32'h0001_0000, 6'd15);
        send_sample(32'hFFFF_0000, 6'd15);
        send_sample(32'h7FFF_FFFF, 6'd15);
        send_sample(32'h8000_0000, 6'd1);
        send_sample(32'h8000_0000, 6'd15);
    endtask

    task automatic test_scaling_saturation();
        program_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'd16, 1'b0);
        send_sample(32'h7FFF_FFFF, 6'd2);
        program_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd16, 1'b0);
        send_sample(32'h8000_0000, 6'd3);
        program_regs(32'h7FFF_FFFF, 32'h0000_0000, 32'd16, 1'b0);
        send_sample(32'h8000_0000, 6'd14);
        send_sample(32'h1234_5678, 6'd1);
    endtask

    task automatic test_unused_index();
        program_regs(32'h0000_4000, SCALE_ONE, 32'd16, 1'b1);
        send_sample(32'h0002_0000, 6'd7);
        send_sample(32'hFFFE_8000, 6'd12);
    endtask

    task automatic randomize_setup();
        logic [31:0] mean_d;
        logic [31:0] scale_d;
        logic [4:0]  nf;
        case ($urandom_range(0, 3))
            0:       mean_d = 32'h0000_0000;
            1:       mean_d = $urandom();
            default: mean_d = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        case ($urandom_range(0, 9))
            0, 1:    scale_d = SCALE_ONE;
            2, 3:    scale_d = $urandom();
            4:       scale_d = 32'h0000_0000;
            5:       scale_d = 32'hFFFF_FFFF;
            default: scale_d = $urandom_range(32'h0040_0000, 32'h0200_0000);
        endcase
        case ($urandom_range(0, 9))
            0:          nf = 5'($urandom_range(0, 31));
            1, 2, 3:    nf = 5'($urandom_range(1, 16));
            default:    nf = 5'd16;
        endcase
        program_regs(mean_d, scale_d, {27'($urandom_range(0, 32'h07FF_FFFF)), nf},
                     $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        logic [31:0] x;
        logic [5:0]  n;
        int          limit;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int seg = 0; seg < 4; seg++) begin
            randomize_setup();
            limit = (cfg_nfact < MAX_DEGREE) ? int'(cfg_nfact) : MAX_DEGREE;
            for (int k = 0; k < SEG_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    8, 9:    x = $urandom();
                    6, 7:    x = cfg_mean + ($urandom_range(0, 32'h0080_0000) - 32'h0040_0000);
                    default: x = cfg_mean + ($urandom_range(0, 32'h0006_0000) - 32'h0003_0000);
                endcase
                if (limit > 0 && $urandom_range(0, 9) < 8) begin
                    n = 6'($urandom_range(0, limit - 1));
                end else begin
                    n = 6'($urandom_range(0, 63));
                end
                send_sample(x, n);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = nhe_pkg::REG_MEAN_OFFSET;
        cfg_wr_data = 32'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 40'd0;
        m_tready    = 1'b0;
        cfg_mean    = 32'd0;
        cfg_scale   = SCALE_ONE;
        cfg_nfact   = 5'd0;
        samples_sent    = 0;
        results_checked = 0;
        reg_writes      = 0;
        mismatches      = 0;
        cycle_count     = 0;
        send_idle_pct   = 31;
        recv_idle_pct   = 88;
        build_norm_table();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_not_initialized();
        test_degree_range();
        test_extreme_samples();
        test_scaling_saturation();
        test_unused_index();
        test_random_traffic(31, 88);
        test_random_traffic(88, 31);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(negedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("covered %0d samples and %0d results over %0d register writes,",
                 samples_sent, results_checked, reg_writes);
        $display("including uninitialized, out-of-range, saturating and stalled traffic");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
